FILE: hw/rtl/shs_pkg.sv
package shs_pkg;

	localparam int SPEED_DIVISOR_DEF = 5;

	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 25;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_MAX_HOMING_STEPS = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HOMING_SPEED = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_FORWARD_DIR = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SENSOR_ACTIVE_LEVEL = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_SENSOR_PRESENT = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_CHUNK_LIMIT = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_FWD_TRAVEL_LIMIT = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_REV_TRAVEL_LIMIT = 3'd7;

	localparam logic [15:0] HOMING_SPEED_RST = 16'd1000;
	localparam logic [7:0] CHUNK_LIMIT_RST = 8'd255;

	// opcodes
	localparam logic [1:0] OP_START = 2'd0;
	localparam logic [1:0] OP_MOVE_DONE = 2'd1;
	localparam logic [1:0] OP_TICK = 2'd2;
	localparam logic [1:0] OP_NONE = 2'd3;

	// result codes
	localparam logic [2:0] RC_OK = 3'd0;
	localparam logic [2:0] RC_ABOVE_LIMIT = 3'd1;
	localparam logic [2:0] RC_BELOW_LIMIT = 3'd2;
	localparam logic [2:0] RC_ZERO_TIMEOUT = 3'd3;
	localparam logic [2:0] RC_STEP_LIMIT = 3'd4;
	localparam logic [2:0] RC_TIMEOUT = 3'd5;
	localparam logic [2:0] RC_BAD_STATE = 3'd6;
	localparam logic [2:0] RC_BUSY = 3'd7;

	typedef struct packed {
		logic [23:0] max_homing_steps;
		logic [15:0] homing_speed;
		logic forward_dir;
		logic sensor_active_level;
		logic sensor_present;
		logic [7:0] chunk_limit;
		logic [23:0] forward_travel_limit;
		logic signed [24:0] reverse_travel_limit;
	} cfg_t;

	// request after classification by the front end
	typedef struct packed {
		logic [1:0] opcode;
		logic sensor_active;
		logic above_limit;
		logic below_limit;
		logic zero_timeout;
		logic signed [24:0] correction_offset;
		logic [23:0] timeout_ms;
	} cls_item_t;

endpackage

FILE: hw/rtl/shs_ifs.sv
interface shs_cmd_if;
	logic valid;
	logic ready;
	logic [1:0] opcode;
	logic signed [24:0] correction_offset;
	logic [23:0] timeout_ms;
	logic sensor_level;

	modport source(output valid, opcode, correction_offset, timeout_ms, sensor_level,
		input ready);
	modport sink(input valid, opcode, correction_offset, timeout_ms, sensor_level,
		output ready);
endinterface

interface shs_res_if;
	logic valid;
	logic ready;
	logic move_valid;
	logic move_dir;
	logic [15:0] move_speed;
	logic [7:0] move_pulses;
	logic busy_res;
	logic finished;
	logic [2:0] result_code;
	logic signed [24:0] position;

	modport source(output valid, move_valid, move_dir, move_speed, move_pulses, busy_res,
		finished, result_code, position, input ready);
	modport sink(input valid, move_valid, move_dir, move_speed, move_pulses, busy_res,
		finished, result_code, position, output ready);
endinterface

interface shs_cfg_if;
	logic valid;
	logic ready;
	logic [2:0] index;
	logic [24:0] data;

	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

FILE: hw/rtl/shs_front.sv
module shs_front import shs_pkg::*; (
	input logic clk,
	input logic arst_n,
	shs_cmd_if.sink cmd,
	input cfg_t cfg,
	output logic push_valid,
	output cls_item_t push_item,
	input logic push_ready
);

	logic valid_s1;
	cls_item_t item_s1;
	cls_item_t cls;

	always_comb begin
		cls.opcode = cmd.opcode;
		cls.sensor_active = (cmd.sensor_level == cfg.sensor_active_level);
		cls.above_limit = (cfg.forward_travel_limit != 24'd0) &&
			(cmd.correction_offset > $signed({1'b0, cfg.forward_travel_limit}));
		cls.below_limit = (cfg.reverse_travel_limit != 25'sd0) &&
			(cmd.correction_offset < cfg.reverse_travel_limit);
		cls.zero_timeout = (cmd.timeout_ms == 24'd0);
		cls.correction_offset = cmd.correction_offset;
		cls.timeout_ms = cmd.timeout_ms;
	end

	assign cmd.ready = !valid_s1 || push_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (cmd.valid && cmd.ready) begin
			valid_s1 <= 1'b1;
		end else if (push_ready) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.valid && cmd.ready) begin
			item_s1 <= cls;
		end
	end

	assign push_valid = valid_s1;
	assign push_item = item_s1;

endmodule

FILE: hw/rtl/shs_queue.sv
module shs_queue import shs_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic push_valid,
	input cls_item_t push_item,
	output logic push_ready,
	output logic pop_valid,
	output cls_item_t pop_item,
	input logic pop_ready
);

	cls_item_t entry_q [2];
	logic wr_ptr_q;
	logic rd_ptr_q;
	logic [1:0] count_q;
	logic do_push;
	logic do_pop;

	assign push_ready = (count_q != 2'd2);
	assign pop_valid = (count_q != 2'd0);
	assign pop_item = entry_q[rd_ptr_q];
	assign do_push = push_valid && push_ready;
	assign do_pop = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 2'd1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_item;
		end
	end

endmodule

FILE: hw/rtl/shs_back.sv
module shs_back import shs_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic pop_valid,
	input cls_item_t pop_item,
	output logic pop_ready,
	input cfg_t cfg,
	input logic [15:0] slow_speed,
	shs_res_if.source res
);

	localparam logic [2:0] PH_IDLE = 3'd0;
	localparam logic [2:0] PH_SEEK1 = 3'd1;
	localparam logic [2:0] PH_LEAVE = 3'd2;
	localparam logic [2:0] PH_SEEK2 = 3'd3;
	localparam logic [2:0] PH_CORR = 3'd4;

	localparam logic [24:0] CNT_MAX = '1;
	localparam logic [23:0] ELAPSED_MAX = '1;

	logic [2:0] phase_q, phase_d;
	logic dir_q, dir_d;
	logic [24:0] count_q, count_d;
	logic [24:0] remain_q, remain_d;
	logic [23:0] elapsed_q, elapsed_d;
	logic [23:0] tlimit_q, tlimit_d;
	logic signed [24:0] target_q, target_d;
	logic signed [24:0] axis_q, axis_d;

	logic out_valid_q;
	logic mv_valid_q, mv_dir_q, busy_q, fin_q;
	logic [15:0] mv_speed_q;
	logic [7:0] mv_pulses_q;
	logic [2:0] code_q;
	logic signed [24:0] pos_q;

	logic mv_valid, mv_dir, busy, fin;
	logic [15:0] mv_speed;
	logic [7:0] mv_pulses;
	logic [2:0] code;
	logic [2:0] tick_code;

	logic fire;
	logic [24:0] cnt_inc;
	logic [23:0] el_inc;
	logic over_limit;
	logic signed [24:0] ah_target;
	logic [24:0] ah_abs;
	logic ah_go;
	logic [7:0] lim;
	logic [24:0] chunk_src;
	logic chunk_big;
	logic [7:0] chunk_n;
	logic [24:0] chunk_rest;
	cls_item_t h;

	assign h = pop_item;
	assign fire = pop_valid && (!out_valid_q || res.ready);
	assign pop_ready = !out_valid_q || res.ready;

	assign cnt_inc = (count_q == CNT_MAX) ? count_q : count_q + 25'd1;
	assign el_inc = (elapsed_q == ELAPSED_MAX) ? elapsed_q : elapsed_q + 24'd1;
	assign over_limit = (cfg.max_homing_steps != 24'd0) &&
		(count_q > {1'b0, cfg.max_homing_steps});

	// target used when homing completes: new offset on start, stored one otherwise
	assign ah_target = (phase_q == PH_IDLE) ? h.correction_offset : target_q;
	assign ah_abs = ah_target[24] ? 25'(-ah_target) : 25'(ah_target);

	// one chunk unit, shared by the correction entry and the correction phase
	assign lim = (cfg.chunk_limit == 8'd0) ? 8'd1 : cfg.chunk_limit;
	assign chunk_src = (phase_q == PH_CORR) ? remain_q : ah_abs;
	assign chunk_big = chunk_src > {17'd0, lim};
	assign chunk_n = chunk_big ? lim : chunk_src[7:0];
	assign chunk_rest = chunk_big ? chunk_src - {17'd0, lim} : 25'd0;

	always_comb begin
		phase_d = phase_q;
		dir_d = dir_q;
		count_d = count_q;
		remain_d = remain_q;
		elapsed_d = elapsed_q;
		tlimit_d = tlimit_q;
		target_d = target_q;
		axis_d = axis_q;
		mv_valid = 1'b0;
		mv_dir = 1'b0;
		mv_speed = 16'd0;
		mv_pulses = 8'd0;
		busy = 1'b0;
		fin = 1'b0;
		code = RC_OK;
		tick_code = RC_OK;
		ah_go = 1'b0;

		unique case (h.opcode)
			OP_START: begin
				if (phase_q != PH_IDLE) begin
					busy = 1'b1;
					code = RC_BUSY;
				end else if (h.above_limit) begin
					fin = 1'b1;
					code = RC_ABOVE_LIMIT;
				end else if (h.below_limit) begin
					fin = 1'b1;
					code = RC_BELOW_LIMIT;
				end else if (h.zero_timeout) begin
					fin = 1'b1;
					code = RC_ZERO_TIMEOUT;
				end else begin
					target_d = h.correction_offset;
					tlimit_d = h.timeout_ms;
					elapsed_d = 24'd0;
					count_d = 25'd0;
					remain_d = 25'd0;
					if (!cfg.sensor_present) begin
						ah_go = 1'b1;
					end else if (h.sensor_active) begin
						phase_d = PH_LEAVE;
						dir_d = cfg.forward_dir;
						count_d = 25'd1;
						mv_valid = 1'b1;
						mv_dir = cfg.forward_dir;
						mv_speed = slow_speed;
						mv_pulses = 8'd1;
						busy = 1'b1;
					end else begin
						phase_d = PH_SEEK1;
						dir_d = !cfg.forward_dir;
						count_d = 25'd1;
						mv_valid = 1'b1;
						mv_dir = !cfg.forward_dir;
						mv_speed = cfg.homing_speed;
						mv_pulses = 8'd1;
						busy = 1'b1;
					end
				end
			end
			OP_MOVE_DONE: begin
				unique case (phase_q)
					PH_IDLE: begin
					end
					PH_SEEK1, PH_LEAVE, PH_SEEK2: begin
						if (over_limit) begin
							phase_d = PH_IDLE;
							fin = 1'b1;
							code = RC_STEP_LIMIT;
						end else if (phase_q == PH_SEEK2 && h.sensor_active) begin
							ah_go = 1'b1;
						end else begin
							// one search pulse, possibly after a direction change
							if (phase_q == PH_SEEK1 && h.sensor_active) begin
								phase_d = PH_LEAVE;
								dir_d = cfg.forward_dir;
							end else if (phase_q == PH_LEAVE && !h.sensor_active) begin
								phase_d = PH_SEEK2;
								dir_d = !cfg.forward_dir;
							end
							count_d = cnt_inc;
							mv_valid = 1'b1;
							mv_dir = dir_d;
							mv_speed = (phase_q == PH_SEEK1 && !h.sensor_active) ?
								cfg.homing_speed : slow_speed;
							mv_pulses = 8'd1;
							busy = 1'b1;
						end
					end
					PH_CORR: begin
						if (remain_q == 25'd0) begin
							phase_d = PH_IDLE;
							axis_d = target_q;
							fin = 1'b1;
							code = RC_OK;
						end else begin
							remain_d = chunk_rest;
							mv_valid = 1'b1;
							mv_dir = dir_q;
							mv_speed = cfg.homing_speed;
							mv_pulses = chunk_n;
							busy = 1'b1;
						end
					end
					default: begin
						phase_d = PH_IDLE;
						fin = 1'b1;
						code = RC_BAD_STATE;
					end
				endcase
			end
			OP_TICK: begin
				if (phase_q == PH_IDLE) begin
				end else if (phase_q > PH_CORR) begin
					phase_d = PH_IDLE;
					fin = 1'b1;
					code = RC_BAD_STATE;
				end else begin
					elapsed_d = el_inc;
					if (el_inc > tlimit_q) begin
						tick_code = RC_TIMEOUT;
					end
					// step limit wins over timeout
					if (phase_q != PH_CORR && over_limit) begin
						tick_code = RC_STEP_LIMIT;
					end
					if (tick_code != RC_OK) begin
						phase_d = PH_IDLE;
						fin = 1'b1;
						code = tick_code;
					end else begin
						busy = 1'b1;
					end
				end
			end
			OP_NONE: begin
				busy = (phase_q != PH_IDLE);
			end
			default: begin
			end
		endcase

		// homing done: end at once for zero offset, else open the correction
		if (ah_go) begin
			if (ah_target == 25'sd0) begin
				phase_d = PH_IDLE;
				axis_d = ah_target;
				fin = 1'b1;
				code = RC_OK;
			end else begin
				phase_d = PH_CORR;
				dir_d = ah_target[24] ? !cfg.forward_dir : cfg.forward_dir;
				remain_d = chunk_rest;
				mv_valid = 1'b1;
				mv_dir = dir_d;
				mv_speed = cfg.homing_speed;
				mv_pulses = chunk_n;
				busy = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			dir_q <= 1'b0;
			count_q <= 25'd0;
			remain_q <= 25'd0;
			elapsed_q <= 24'd0;
			tlimit_q <= 24'd0;
			target_q <= 25'sd0;
			axis_q <= 25'sd0;
			out_valid_q <= 1'b0;
		end else begin
			if (fire) begin
				phase_q <= phase_d;
				dir_q <= dir_d;
				count_q <= count_d;
				remain_q <= remain_d;
				elapsed_q <= elapsed_d;
				tlimit_q <= tlimit_d;
				target_q <= target_d;
				axis_q <= axis_d;
				out_valid_q <= 1'b1;
			end else if (res.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			mv_valid_q <= mv_valid;
			mv_dir_q <= mv_dir;
			mv_speed_q <= mv_speed;
			mv_pulses_q <= mv_pulses;
			busy_q <= busy;
			fin_q <= fin;
			code_q <= code;
			pos_q <= axis_d;
		end
	end

	assign res.valid = out_valid_q;
	assign res.move_valid = mv_valid_q;
	assign res.move_dir = mv_dir_q;
	assign res.move_speed = mv_speed_q;
	assign res.move_pulses = mv_pulses_q;
	assign res.busy_res = busy_q;
	assign res.finished = fin_q;
	assign res.result_code = code_q;
	assign res.position = pos_q;

endmodule

FILE: hw/rtl/stepper_homing_sequencer_top.sv
// a request passes the front-end register and the two-entry queue before its result is registered
// throughput: one request per cycle while the result side does not stall, set by the sequencing unit
// a two-entry queue between classifier and sequencer absorbs output stalls
// reset: asynchronous, active low; phase idle, counters and position cleared,
// registers at their power-up values
module stepper_homing_sequencer_top import shs_pkg::*; #(
	parameter int SPEED_DIVISOR = SPEED_DIVISOR_DEF
) (
	input logic clk,
	input logic arst_n,
	shs_cmd_if.sink cmd,
	shs_res_if.source res,
	shs_cfg_if.sink cfg
);

	// reciprocal of the divisor, exact for 16-bit speeds
	localparam logic [32:0] RECIP =
		33'(((64'd1 << 32) + 64'(SPEED_DIVISOR) - 64'd1) / 64'(SPEED_DIVISOR));
	localparam logic [15:0] SLOW_RST = 16'(HOMING_SPEED_RST / SPEED_DIVISOR);

	cfg_t cfg_q;
	logic [15:0] slow_q;
	logic [48:0] slow_prod;

	logic push_valid, push_ready, pop_valid, pop_ready;
	cls_item_t push_item, pop_item;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.max_homing_steps <= 24'd0;
			cfg_q.homing_speed <= HOMING_SPEED_RST;
			cfg_q.forward_dir <= 1'b0;
			cfg_q.sensor_active_level <= 1'b1;
			cfg_q.sensor_present <= 1'b1;
			cfg_q.chunk_limit <= CHUNK_LIMIT_RST;
			cfg_q.forward_travel_limit <= 24'd0;
			cfg_q.reverse_travel_limit <= 25'sd0;
		end else if (cfg.valid && cfg.ready) begin
			unique case (cfg.index)
				REG_MAX_HOMING_STEPS: cfg_q.max_homing_steps <= cfg.data[23:0];
				REG_HOMING_SPEED: cfg_q.homing_speed <= cfg.data[15:0];
				REG_FORWARD_DIR: cfg_q.forward_dir <= cfg.data[0];
				REG_SENSOR_ACTIVE_LEVEL: cfg_q.sensor_active_level <= cfg.data[0];
				REG_SENSOR_PRESENT: cfg_q.sensor_present <= cfg.data[0];
				REG_CHUNK_LIMIT: cfg_q.chunk_limit <= cfg.data[7:0];
				REG_FWD_TRAVEL_LIMIT: cfg_q.forward_travel_limit <= cfg.data[23:0];
				REG_REV_TRAVEL_LIMIT: cfg_q.reverse_travel_limit <= $signed(cfg.data);
				default: begin
				end
			endcase
		end
	end

	assign slow_prod = 49'(cfg_q.homing_speed) * 49'(RECIP);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slow_q <= SLOW_RST;
		end else begin
			slow_q <= slow_prod[47:32];
		end
	end

	shs_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd),
		.cfg(cfg_q),
		.push_valid(push_valid),
		.push_item(push_item),
		.push_ready(push_ready)
	);

	shs_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push_valid(push_valid),
		.push_item(push_item),
		.push_ready(push_ready),
		.pop_valid(pop_valid),
		.pop_item(pop_item),
		.pop_ready(pop_ready)
	);

	shs_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.pop_valid(pop_valid),
		.pop_item(pop_item),
		.pop_ready(pop_ready),
		.cfg(cfg_q),
		.slow_speed(slow_q),
		.res(res)
	);

endmodule

FILE: test/testbench.sv
`timescale 1ns / 1ps

module testbench;
	import shs_pkg::*;

	typedef enum logic [2:0] {
		HS_IDLE,
		HS_SEEK,
		HS_LEAVE,
		HS_RESEEK,
		HS_CORRECT
	} seq_phase_t;

	typedef struct {
		logic [1:0] op;
		logic signed [24:0] offs;
		logic [23:0] tmo;
		logic lvl;
	} homing_req_t;

	typedef struct packed {
		logic move_valid;
		logic move_dir;
		logic [15:0] move_speed;
		logic [7:0] move_pulses;
		logic busy_res;
		logic finished;
		logic [2:0] result_code;
		logic signed [24:0] position;
	} move_res_t;

	logic clk = 1'b0;
	logic arst_n;

	shs_cmd_if cmd_ch();
	shs_res_if res_ch();
	shs_cfg_if cfg_ch();

	stepper_homing_sequencer_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd_ch),
		.res(res_ch),
		.cfg(cfg_ch)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// register copies, tracked at each accepted write
	logic [23:0] cfg_max_steps = '0;
	logic [15:0] cfg_speed = HOMING_SPEED_RST;
	logic cfg_fwd_dir = 1'b0;
	logic cfg_active_level = 1'b1;
	logic cfg_sensor_fitted = 1'b1;
	logic [7:0] cfg_chunk = CHUNK_LIMIT_RST;
	logic [23:0] cfg_fwd_limit = '0;
	logic signed [24:0] cfg_rev_limit = '0;

	// sequencer state as predicted
	seq_phase_t hs_phase = HS_IDLE;
	logic hs_dir = 1'b0;
	logic [24:0] hs_pulses = '0;
	logic [24:0] hs_remain = '0;
	logic [23:0] hs_elapsed = '0;
	logic [23:0] hs_tmo_limit = '0;
	logic signed [24:0] hs_target = '0;
	logic signed [24:0] hs_axis_pos = '0;

	homing_req_t pending_reqs[$];
	move_res_t open_results[$];
	int n_queued = 0;
	int n_accepted = 0;
	int n_errors = 0;
	logic cmd_fired = 1'b0;

	int gap_left = 0;
	int burst_left = 0;
	int hold_left = 0;
	logic hold_done = 1'b0;
	logic [7:0] rdy_tick = '0;
	logic [1:0] rdy_mode = '0;

	function automatic move_res_t end_run(input logic [2:0] code);
		move_res_t r;
		r = '0;
		if (code == RC_OK)
			hs_axis_pos = hs_target;
		hs_phase = HS_IDLE;
		r.finished = 1'b1;
		r.result_code = code;
		return r;
	endfunction

	function automatic move_res_t step_pulse(input logic [15:0] speed);
		move_res_t r;
		r = '0;
		if (hs_pulses != '1)
			hs_pulses = hs_pulses + 1'b1;
		r.move_valid = 1'b1;
		r.move_dir = hs_dir;
		r.move_speed = speed;
		r.move_pulses = 8'd1;
		r.busy_res = 1'b1;
		return r;
	endfunction

	function automatic move_res_t correction_move();
		move_res_t r;
		logic [24:0] lim;
		r = '0;
		// a zero chunk limit behaves as one
		lim = (cfg_chunk == 8'd0) ? 25'd1 : {17'd0, cfg_chunk};
		if (hs_remain > lim) begin
			r.move_pulses = lim[7:0];
			hs_remain = hs_remain - lim;
		end else begin
			r.move_pulses = hs_remain[7:0];
			hs_remain = '0;
		end
		r.move_valid = 1'b1;
		r.move_dir = hs_dir;
		r.move_speed = cfg_speed;
		r.busy_res = 1'b1;
		return r;
	endfunction

	function automatic move_res_t after_search();
		if (hs_target == 0)
			return end_run(RC_OK);
		if (hs_target > 0) begin
			hs_dir = cfg_fwd_dir;
			hs_remain = hs_target;
		end else begin
			hs_dir = ~cfg_fwd_dir;
			hs_remain = -hs_target;
		end
		hs_phase = HS_CORRECT;
		return correction_move();
	endfunction

	function automatic logic steps_exceeded();
		return cfg_max_steps != '0 && hs_pulses > {1'b0, cfg_max_steps};
	endfunction

	function automatic move_res_t compute_move(input homing_req_t req);
		move_res_t r;
		logic hit;
		logic [15:0] slow;
		logic [2:0] code;
		int offs_i;
		int fwd_i;
		int rev_i;
		r = '0;
		hit = (req.lvl == cfg_active_level);
		slow = 16'(cfg_speed / SPEED_DIVISOR_DEF);
		offs_i = int'(req.offs);
		fwd_i = int'(cfg_fwd_limit);
		rev_i = int'(cfg_rev_limit);
		case (req.op)
		OP_START: begin
			if (hs_phase != HS_IDLE) begin
				r.busy_res = 1'b1;
				r.result_code = RC_BUSY;
			end else if (cfg_fwd_limit != '0 && offs_i > fwd_i) begin
				r.finished = 1'b1;
				r.result_code = RC_ABOVE_LIMIT;
			end else if (rev_i != 0 && offs_i < rev_i) begin
				r.finished = 1'b1;
				r.result_code = RC_BELOW_LIMIT;
			end else if (req.tmo == '0) begin
				r.finished = 1'b1;
				r.result_code = RC_ZERO_TIMEOUT;
			end else begin
				hs_target = req.offs;
				hs_tmo_limit = req.tmo;
				hs_elapsed = '0;
				hs_pulses = '0;
				hs_remain = '0;
				if (!cfg_sensor_fitted) begin
					r = after_search();
				end else if (hit) begin
					hs_phase = HS_LEAVE;
					hs_dir = cfg_fwd_dir;
					r = step_pulse(slow);
				end else begin
					hs_phase = HS_SEEK;
					hs_dir = ~cfg_fwd_dir;
					r = step_pulse(cfg_speed);
				end
			end
		end
		OP_MOVE_DONE: begin
			case (hs_phase)
			HS_IDLE: r = '0;
			HS_SEEK: begin
				if (steps_exceeded()) begin
					r = end_run(RC_STEP_LIMIT);
				end else if (hit) begin
					hs_phase = HS_LEAVE;
					hs_dir = cfg_fwd_dir;
					r = step_pulse(slow);
				end else begin
					r = step_pulse(cfg_speed);
				end
			end
			HS_LEAVE: begin
				if (steps_exceeded()) begin
					r = end_run(RC_STEP_LIMIT);
				end else begin
					if (!hit) begin
						hs_phase = HS_RESEEK;
						hs_dir = ~cfg_fwd_dir;
					end
					r = step_pulse(slow);
				end
			end
			HS_RESEEK: begin
				if (steps_exceeded())
					r = end_run(RC_STEP_LIMIT);
				else if (hit)
					r = after_search();
				else
					r = step_pulse(slow);
			end
			HS_CORRECT: begin
				if (hs_remain == '0)
					r = end_run(RC_OK);
				else
					r = correction_move();
			end
			default: r = end_run(RC_BAD_STATE);
			endcase
		end
		OP_TICK: begin
			if (hs_phase == HS_IDLE) begin
				r = '0;
			end else if (hs_phase > HS_CORRECT) begin
				r = end_run(RC_BAD_STATE);
			end else begin
				// timeout checked first, step limit wins when both hold
				code = RC_OK;
				if (hs_elapsed != '1)
					hs_elapsed = hs_elapsed + 1'b1;
				if (hs_elapsed > hs_tmo_limit)
					code = RC_TIMEOUT;
				if (hs_phase != HS_CORRECT && steps_exceeded())
					code = RC_STEP_LIMIT;
				if (code != RC_OK)
					r = end_run(code);
				else
					r.busy_res = 1'b1;
			end
		end
		default: r.busy_res = (hs_phase != HS_IDLE);
		endcase
		r.position = hs_axis_pos;
		return r;
	endfunction

	task automatic flag_mismatch(input string msg);
		n_errors++;
		if (n_errors <= 50)
			$display("[%0t] %s", $time, msg);
	endtask

	task automatic check_field(input string name, input longint got, input longint want);
		if (got != want)
			flag_mismatch($sformatf("%s: got %0d, expected %0d", name, got, want));
	endtask

	// sender: bursts of random length separated by random gaps
	always @(negedge clk) begin
		homing_req_t nxt;
		if (!cmd_ch.valid || cmd_fired) begin
			cmd_fired = 1'b0;
			if (gap_left != 0) begin
				gap_left <= gap_left - 1;
				cmd_ch.valid <= 1'b0;
			end else if (pending_reqs.size() != 0) begin
				nxt = pending_reqs.pop_front();
				cmd_ch.valid <= 1'b1;
				cmd_ch.opcode <= nxt.op;
				cmd_ch.correction_offset <= nxt.offs;
				cmd_ch.timeout_ms <= nxt.tmo;
				cmd_ch.sensor_level <= nxt.lvl;
				if (burst_left <= 1) begin
					burst_left <= $urandom_range(1, 24);
					gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
				end else begin
					burst_left <= burst_left - 1;
				end
			end else begin
				cmd_ch.valid <= 1'b0;
			end
		end
	end

	// one long hold-off on the result side so the block backs up into its input
	always @(negedge clk) begin
		if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end else if (!hold_done && n_accepted >= 150 && pending_reqs.size() >= 8) begin
			hold_left <= 400;
			hold_done <= 1'b1;
		end
	end

	always @(negedge clk) begin
		rdy_tick <= rdy_tick + 1'b1;
		if (rdy_tick[5:0] == 6'd0)
			rdy_mode <= 2'($urandom_range(0, 3));
		if (hold_left != 0) begin
			res_ch.ready <= 1'b0;
		end else begin
			case (rdy_mode)
			2'd0: res_ch.ready <= 1'b1;
			2'd1: res_ch.ready <= 1'($urandom_range(0, 1));
			2'd2: res_ch.ready <= (rdy_tick[1:0] != 2'd3);
			default: res_ch.ready <= ($urandom_range(0, 3) == 0);
			endcase
		end
	end

	always @(posedge clk) begin
		homing_req_t req;
		move_res_t got;
		move_res_t want;
		if (arst_n) begin
			if (cfg_ch.valid && cfg_ch.ready) begin
				case (cfg_ch.index)
				REG_MAX_HOMING_STEPS: cfg_max_steps = cfg_ch.data[23:0];
				REG_HOMING_SPEED: cfg_speed = cfg_ch.data[15:0];
				REG_FORWARD_DIR: cfg_fwd_dir = cfg_ch.data[0];
				REG_SENSOR_ACTIVE_LEVEL: cfg_active_level = cfg_ch.data[0];
				REG_SENSOR_PRESENT: cfg_sensor_fitted = cfg_ch.data[0];
				REG_CHUNK_LIMIT: cfg_chunk = cfg_ch.data[7:0];
				REG_FWD_TRAVEL_LIMIT: cfg_fwd_limit = cfg_ch.data[23:0];
				REG_REV_TRAVEL_LIMIT: cfg_rev_limit = cfg_ch.data;
				default: ;
				endcase
			end
			if (res_ch.valid && res_ch.ready) begin
				if (open_results.size() == 0) begin
					flag_mismatch("result with no request outstanding");
				end else begin
					want = open_results.pop_front();
					got.move_valid = res_ch.move_valid;
					got.move_dir = res_ch.move_dir;
					got.move_speed = res_ch.move_speed;
					got.move_pulses = res_ch.move_pulses;
					got.busy_res = res_ch.busy_res;
					got.finished = res_ch.finished;
					got.result_code = res_ch.result_code;
					got.position = res_ch.position;
					check_field("move_valid", longint'(got.move_valid),
						longint'(want.move_valid));
					check_field("move_dir", longint'(got.move_dir), longint'(want.move_dir));
					check_field("move_speed", longint'(got.move_speed),
						longint'(want.move_speed));
					check_field("move_pulses", longint'(got.move_pulses),
						longint'(want.move_pulses));
					check_field("busy_res", longint'(got.busy_res), longint'(want.busy_res));
					check_field("finished", longint'(got.finished), longint'(want.finished));
					check_field("result_code", longint'(got.result_code),
						longint'(want.result_code));
					check_field("position", longint'(got.position), longint'(want.position));
				end
			end
			if (cmd_ch.valid && cmd_ch.ready) begin
				cmd_fired = 1'b1;
				n_accepted++;
				req.op = cmd_ch.opcode;
				req.offs = cmd_ch.correction_offset;
				req.tmo = cmd_ch.timeout_ms;
				req.lvl = cmd_ch.sensor_level;
				open_results.push_back(compute_move(req));
			end
		end
	end

	task automatic queue_req(input logic [1:0] op, input logic signed [24:0] offs,
		input logic [23:0] tmo, input logic lvl);
		homing_req_t req;
		req.op = op;
		req.offs = offs;
		req.tmo = tmo;
		req.lvl = lvl;
		pending_reqs.push_back(req);
		n_queued++;
	endtask

	// move-done with the given sensor level, sometimes preceded by a tick or noise
	task automatic queue_move(input logic lvl);
		logic [1:0] op;
		if ($urandom_range(0, 6) == 0)
			queue_req(OP_TICK, 25'($urandom), 24'($urandom), 1'($urandom));
		if ($urandom_range(0, 24) == 0) begin
			op = 2'($urandom);
			queue_req(op, 25'($urandom),
				(op == OP_START) ? 24'($urandom_range(1, 8)) : 24'($urandom),
				1'($urandom));
		end
		queue_req(OP_MOVE_DONE, 25'($urandom), 24'($urandom), lvl);
	endtask

	task automatic wait_quiet();
		while (!(n_accepted == n_queued && open_results.size() == 0))
			@(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	// bring the sequencer back to idle by walking it through its phases
	task automatic settle_run();
		wait_quiet();
		while (hs_phase != HS_IDLE) begin
			if (hs_tmo_limit <= 24'd64)
				queue_req(OP_TICK, 25'($urandom), 24'($urandom), 1'($urandom));
			else if (hs_phase == HS_LEAVE)
				queue_req(OP_MOVE_DONE, 25'($urandom), 24'($urandom), ~cfg_active_level);
			else
				queue_req(OP_MOVE_DONE, 25'($urandom), 24'($urandom), cfg_active_level);
			wait_quiet();
		end
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [24:0] val);
		@(negedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data <= val;
		do
			@(posedge clk);
		while (!cfg_ch.ready);
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
	endtask

	task automatic load_config(input logic [23:0] steps, input logic [15:0] speed,
		input logic fdir, input logic act, input logic fitted, input logic [7:0] chunk,
		input logic [23:0] fwd, input logic [24:0] rev);
		write_reg(REG_MAX_HOMING_STEPS, {1'b0, steps});
		write_reg(REG_HOMING_SPEED, {9'd0, speed});
		write_reg(REG_FORWARD_DIR, {24'd0, fdir});
		write_reg(REG_SENSOR_ACTIVE_LEVEL, {24'd0, act});
		write_reg(REG_SENSOR_PRESENT, {24'd0, fitted});
		write_reg(REG_CHUNK_LIMIT, {17'd0, chunk});
		write_reg(REG_FWD_TRAVEL_LIMIT, {1'b0, fwd});
		write_reg(REG_REV_TRAVEL_LIMIT, rev);
	endtask

	task automatic random_config();
		logic [23:0] steps;
		logic [15:0] speed;
		logic [7:0] chunk;
		logic [23:0] fwd;
		logic [24:0] rev;
		case ($urandom_range(0, 3))
		0: steps = '0;
		1: steps = '1;
		default: steps = 24'($urandom_range(1, 24));
		endcase
		case ($urandom_range(0, 3))
		0: speed = '0;
		1: speed = '1;
		default: speed = 16'($urandom);
		endcase
		case ($urandom_range(0, 4))
		0: chunk = 8'd0;
		1: chunk = 8'd255;
		2: chunk = 8'd1;
		default: chunk = 8'($urandom_range(2, 254));
		endcase
		case ($urandom_range(0, 3))
		0: fwd = '0;
		1: fwd = '1;
		default: fwd = 24'($urandom_range(20, 400));
		endcase
		case ($urandom_range(0, 3))
		0: rev = '0;
		1: rev = 25'h1000000;
		default: rev = -25'($urandom_range(20, 400));
		endcase
		load_config(steps, speed, 1'($urandom), 1'($urandom), $urandom_range(0, 4) != 0,
			chunk, fwd, rev);
	endtask

	// one homing run: seek, back off, seek again, then the correction moves
	task automatic gen_run();
		logic signed [24:0] offs;
		logic [23:0] tmo;
		logic on_lvl;
		int dist_abs;
		int lim;
		int n;
		on_lvl = cfg_active_level;
		if ($urandom_range(0, 9) == 0) begin
			// far offsets only with a short timeout so the run ends on ticks
			offs = 25'($urandom);
			tmo = 24'($urandom_range(1, 8));
		end else begin
			offs = 25'(int'($urandom_range(0, 400)) - 200);
			case ($urandom_range(0, 9))
			0: tmo = '1;
			1: tmo = '0;
			2, 3: tmo = 24'($urandom_range(1, 12));
			default: tmo = 24'($urandom_range(13, 100000));
			endcase
		end
		queue_req(OP_START, offs, tmo, ($urandom_range(0, 4) == 0) ? on_lvl : ~on_lvl);
		repeat ($urandom_range(0, 5)) queue_move(~on_lvl);
		queue_move(on_lvl);
		repeat ($urandom_range(0, 3)) queue_move(on_lvl);
		queue_move(~on_lvl);
		repeat ($urandom_range(0, 5)) queue_move(~on_lvl);
		queue_move(on_lvl);
		dist_abs = int'(offs);
		if (dist_abs < 0)
			dist_abs = -dist_abs;
		lim = (cfg_chunk == 8'd0) ? 1 : int'(cfg_chunk);
		n = (dist_abs + lim - 1) / lim + 1;
		if (n > 30)
			n = $urandom_range(0, 30);
		repeat (n) queue_move(1'($urandom));
		settle_run();
	endtask

	initial begin
		arst_n = 1'b0;
		cmd_ch.valid = 1'b0;
		cmd_ch.opcode = OP_NONE;
		cmd_ch.correction_offset = '0;
		cmd_ch.timeout_ms = '0;
		cmd_ch.sensor_level = 1'b0;
		res_ch.ready = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = REG_MAX_HOMING_STEPS;
		cfg_ch.data = '0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// power-up settings: idle requests, rejected start, timeout and a full run
		queue_req(OP_TICK, 25'h0FFFFFF, 24'hFFFFFF, 1'b1);
		queue_req(OP_MOVE_DONE, 25'h1000000, 24'h000000, 1'b0);
		queue_req(OP_NONE, 25'h1FFFFFF, 24'h800000, 1'b1);
		queue_req(OP_START, 25'd5, 24'd0, 1'b0);
		queue_req(OP_START, 25'h1000000, 24'd2, 1'b1);
		queue_req(OP_START, 25'd7, 24'd9, 1'b0);
		queue_req(OP_NONE, 25'd0, 24'd0, 1'b0);
		queue_req(OP_MOVE_DONE, 25'd0, 24'd0, 1'b1);
		queue_req(OP_MOVE_DONE, 25'd0, 24'd0, 1'b0);
		repeat (3) queue_req(OP_TICK, 25'd0, 24'd0, 1'b0);
		queue_req(OP_START, 25'd40, 24'hFFFFFF, 1'b0);
		queue_req(OP_MOVE_DONE, 25'd0, 24'd0, 1'b1);
		queue_req(OP_MOVE_DONE, 25'd0, 24'd0, 1'b0);
		queue_req(OP_MOVE_DONE, 25'd0, 24'd0, 1'b1);
		queue_req(OP_MOVE_DONE, 25'd0, 24'd0, 1'b0);
		settle_run();

		// step limit and timeout on the same tick
		load_config(24'd3, 16'hFFFF, 1'b1, 1'b0, 1'b1, 8'd1, 24'hFFFFFF, 25'h1000000);
		queue_req(OP_START, 25'd10, 24'd1, 1'b1);
		queue_req(OP_TICK, 25'd0, 24'd0, 1'b0);
		repeat (3) queue_req(OP_MOVE_DONE, 25'd0, 24'd0, 1'b1);
		queue_req(OP_TICK, 25'd0, 24'd0, 1'b0);
		settle_run();

		// no sensor fitted, travel limits, zero chunk limit
		load_config(24'hFFFFFF, 16'd0, 1'b0, 1'b1, 1'b0, 8'd0, 24'd1000, -25'd1000);
		queue_req(OP_START, 25'd1001, 24'd5, 1'b0);
		queue_req(OP_START, -25'd1001, 24'd5, 1'b0);
		queue_req(OP_START, 25'd0, 24'd5, 1'b1);
		queue_req(OP_START, -25'd2, 24'd3, 1'b0);
		repeat (2) queue_req(OP_MOVE_DONE, 25'd0, 24'd0, 1'b0);
		settle_run();

		while (n_queued < 480) begin
			random_config();
			repeat ($urandom_range(4, 10))
				if (n_queued < 480)
					gen_run();
		end
		settle_run();
		repeat (8) @(posedge clk);

		if (n_errors == 0)
			$display("stepper_homing_sequencer_top verification clean");
		else
			$display("stepper_homing_sequencer_top verification failed");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("stepper_homing_sequencer_top verification failed");
		$finish;
	end

endmodule
